### sv/bcf_pkg.sv
// ---------------------------------------------------------------------------
// bcf_pkg
// Shared constants for the packed-decimal field encoder with complement bytes.
// ---------------------------------------------------------------------------
package bcf_pkg;

	localparam int MAX_BYTES  = 5;
	localparam int VALUE_W    = 32;
	localparam int BCD_W      = 8 * MAX_BYTES;
	localparam int STEPS      = VALUE_W;
	localparam int STEP_W     = $clog2(STEPS);
	localparam int COUNT_W    = 3;
	localparam int BYTE_IDX_W = $clog2(MAX_BYTES + 1);
	localparam int PAIR_W     = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

	localparam logic [7:0] BYTE_MASK = 8'hFF;

endpackage

### sv/bcf_dabble.sv
// ---------------------------------------------------------------------------
// bcf_dabble
// One shift-add-3 step of binary to packed decimal conversion: each digit
// of five or more gets 3 added, then the binary and decimal words shift
// left by one bit as a pair.
// ---------------------------------------------------------------------------
module bcf_dabble (
	input  logic [bcf_pkg::VALUE_W-1:0] bin,
	input  logic [bcf_pkg::BCD_W-1:0]   bcd,
	output logic [bcf_pkg::VALUE_W-1:0] bin_next,
	output logic [bcf_pkg::BCD_W-1:0]   bcd_next
);
	import bcf_pkg::*;

	logic [BCD_W-1:0] bcd_adj;

	always_comb begin
		for (int d = 0; d < BCD_W / 4; d++) begin
			if (bcd[4*d +: 4] >= 4'd5) begin
				bcd_adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
			end else begin
				bcd_adj[4*d +: 4] = bcd[4*d +: 4];
			end
		end
	end

	// bit shifted out of the top digit carries weight 10^digits and is dropped
	assign bcd_next = {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
	assign bin_next = {bin[VALUE_W-2:0], 1'b0};

endmodule

### sv/bcd_complement_field_encoder.sv
// ---------------------------------------------------------------------------
// bcd_complement_field_encoder
// Binary to packed decimal encoder that sends each byte followed by its
// bitwise complement.
// ---------------------------------------------------------------------------
// An item is accepted, then converted by shift-add-3 in one shared step unit
// (one input bit per cycle), then sent at one result byte per cycle while the
// output side keeps up. in_ready is low from the acceptance until the final
// result has been loaded into the output register; that result may still be
// waiting when the next item is taken. The value is reduced modulo 10^(2n); a
// byte count above MAX_BYTES counts as MAX_BYTES, and a count of zero is taken
// and yields no result.
module bcd_complement_field_encoder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [bcf_pkg::VALUE_W-1:0]  value,
	input  logic [bcf_pkg::COUNT_W-1:0]  byte_count,
	input  logic                         most_significant_first,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [7:0]                   data_byte,
	output logic                         is_complement,
	output logic                         last
);
	import bcf_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	state_t                 state_q;
	logic [VALUE_W-1:0]     bin_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [VALUE_W-1:0]     bin_next;
	logic [BCD_W-1:0]       bcd_next;
	logic [STEP_W-1:0]      step_q;
	logic [BYTE_IDX_W-1:0]  nbytes_q;
	logic [BYTE_IDX_W-1:0]  k_q;
	logic                   msf_q;
	logic                   comp_q;
	logic                   out_valid_q;
	logic [7:0]             data_byte_q;
	logic                   is_comp_q;
	logic                   last_q;

	logic [BYTE_IDX_W-1:0]  n_sat;
	logic [BYTE_IDX_W-1:0]  pair;
	logic [7:0]             packed_byte;
	logic                   out_fire;
	logic                   out_load;
	logic                   final_byte;

	bcf_dabble u_dabble (
		.bin      (bin_q),
		.bcd      (bcd_q),
		.bin_next (bin_next),
		.bcd_next (bcd_next)
	);

	always_comb begin
		if (byte_count > COUNT_W'(MAX_BYTES)) begin
			n_sat = BYTE_IDX_W'(MAX_BYTES);
		end else begin
			n_sat = BYTE_IDX_W'(byte_count);
		end
	end

	assign pair        = msf_q ? (nbytes_q - k_q - BYTE_IDX_W'(1)) : k_q;
	assign packed_byte = bcd_q[8*pair[PAIR_W-1:0] +: 8];
	assign final_byte  = (k_q == nbytes_q - BYTE_IDX_W'(1));
	assign out_fire    = out_valid_q & out_ready;
	// in the emit state, load a result whenever the output register is free this cycle
	assign out_load    = (state_q == ST_EMIT) & (~out_valid_q | out_fire);

	assign in_ready      = (state_q == ST_IDLE);
	assign out_valid     = out_valid_q;
	assign data_byte     = data_byte_q;
	assign is_complement = is_comp_q;
	assign last          = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bin_q       <= '0;
			bcd_q       <= '0;
			step_q      <= '0;
			nbytes_q    <= '0;
			k_q         <= '0;
			msf_q       <= 1'b0;
			comp_q      <= 1'b0;
			out_valid_q <= 1'b0;
			data_byte_q <= '0;
			is_comp_q   <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						bin_q    <= value;
						bcd_q    <= '0;
						nbytes_q <= n_sat;
						msf_q    <= most_significant_first;
						step_q   <= '0;
						if (n_sat != '0) begin
							state_q <= ST_CONV;
						end
					end
				end
				ST_CONV: begin
					bin_q  <= bin_next;
					bcd_q  <= bcd_next;
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(STEPS - 1)) begin
						k_q     <= '0;
						comp_q  <= 1'b0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						data_byte_q <= comp_q ? (packed_byte ^ BYTE_MASK) : packed_byte;
						is_comp_q   <= comp_q;
						last_q      <= comp_q & final_byte;
						comp_q      <= ~comp_q;
						if (comp_q) begin
							k_q <= k_q + BYTE_IDX_W'(1);
							if (final_byte) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### sv/bcf_checker.sv
// ---------------------------------------------------------------------------
// bcf_checker
// Port-level checks of the result stream: byte/complement alternation, the
// complement value, the last mark and output stability under stall.
// ---------------------------------------------------------------------------
module bcf_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [7:0]                   data_byte,
	input logic                         is_complement,
	input logic                         last
);
	import bcf_pkg::*;

	logic       expect_comp_q;
	logic [7:0] prev_byte_q;

	// track which half of the byte pair the next output transaction must be
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_comp_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			expect_comp_q <= ~expect_comp_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid && out_ready && !is_complement) begin
			prev_byte_q <= data_byte;
		end
	end

	a_alternate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_complement == expect_comp_q))
		else $error("result order broken: byte and complement do not alternate");

	a_complement: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_complement) |-> (data_byte == (prev_byte_q ^ BYTE_MASK)))
		else $error("complement byte does not match the preceding byte");

	a_last_on_comp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> is_complement)
		else $error("last mark on a non-complement byte");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(data_byte) && $stable(is_complement) && $stable(last)))
		else $error("output transaction changed while stalled");

endmodule

bind bcd_complement_field_encoder bcf_checker u_bcf_checker (.*);
